// ===== rtl/core/hhlt_pkg.sv =====
// Package for the HTTP header line tokenizer.
// Holds the word types, parse mode and status codes, and the byte class check.
// No dependencies.
`timescale 1ns / 1ps

package hhlt_pkg;

	// Input word: one raw header byte and the start-of-block flag
	typedef struct packed {
		logic [7:0] data_byte;
		logic       block_start;
	} in_word_t;

	// Output word: one emitted byte with its role, deferred spaces and status
	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] role;
		logic [7:0] spaces_before;
		logic [2:0] line_status;
	} out_word_t;

	// Parse modes
	typedef enum logic [2:0] {
		MODE_KEY_START = 3'd0,
		MODE_KEY       = 3'd1,
		MODE_VAL_LEAD  = 3'd2,
		MODE_VAL       = 3'd3,
		MODE_START_CR  = 3'd4,
		MODE_VAL_CR    = 3'd5,
		MODE_ERR_KEY   = 3'd6,
		MODE_ERR_VAL   = 3'd7
	} mode_t;

	// Parser state carried from byte to byte
	typedef struct packed {
		mode_t      mode;
		logic       key_ends_space;
		logic [7:0] pending_spaces;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		mode:           MODE_KEY_START,
		key_ends_space: 1'b0,
		pending_spaces: 8'd0
	};

	// Roles
	localparam logic [1:0] ROLE_NONE = 2'd0;
	localparam logic [1:0] ROLE_KEY  = 2'd1;
	localparam logic [1:0] ROLE_VAL  = 2'd2;

	// Line status codes
	localparam logic [2:0] ST_BUSY    = 3'd0;
	localparam logic [2:0] ST_OK      = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_BAD_KEY = 3'd3;
	localparam logic [2:0] ST_BAD_VAL = 3'd4;

	// Character codes
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_CTRL_MAX = 8'd31;
	localparam logic [7:0] CH_DEL   = 8'd127;
	localparam logic [7:0] SPACES_MAX = 8'hFF;

	// Printable ASCII or tab
	function automatic logic text_byte(input logic [7:0] b);
		return ((b > CH_CTRL_MAX) && (b < CH_DEL)) || (b == CH_TAB);
	endfunction

endpackage

// ===== rtl/core/hhlt_step.sv =====
// Per-byte next-state and result logic of the header line tokenizer.
// Purely combinational; depends on hhlt_pkg.
`timescale 1ns / 1ps

module hhlt_step (
	input  hhlt_pkg::in_word_t     in_word,
	input  hhlt_pkg::parse_state_t state,
	output hhlt_pkg::out_word_t    result,
	output hhlt_pkg::parse_state_t state_nxt
);
	import hhlt_pkg::*;

	parse_state_t cur;
	logic [7:0]   b;

	// Restart from the line-start state when a new block begins
	assign cur = in_word.block_start ? STATE_RESET : state;
	assign b   = in_word.data_byte;

	always_comb begin
		result    = '0;
		state_nxt = cur;
		unique case (cur.mode)
			MODE_KEY_START, MODE_KEY: begin
				priority if (b == CH_COLON) begin
					if (cur.mode == MODE_KEY_START || cur.key_ends_space) begin
						state_nxt.mode     = MODE_ERR_KEY;
						result.line_status = ST_BAD_KEY;
					end else begin
						state_nxt.mode           = MODE_VAL_LEAD;
						state_nxt.pending_spaces = 8'd0;
					end
				end else if (b == CH_LF) begin
					if (cur.mode == MODE_KEY_START) begin
						result.line_status = ST_EMPTY;
						state_nxt          = STATE_RESET;
					end else begin
						state_nxt.mode     = MODE_ERR_KEY;
						result.line_status = ST_BAD_KEY;
					end
				end else if (b == CH_CR && cur.mode == MODE_KEY_START) begin
					state_nxt.mode = MODE_START_CR;
				end else if (text_byte(b)) begin
					result.out_byte          = b;
					result.role              = ROLE_KEY;
					state_nxt.key_ends_space = (b == CH_SPACE);
					state_nxt.mode           = MODE_KEY;
				end else begin
					state_nxt.mode     = MODE_ERR_KEY;
					result.line_status = ST_BAD_KEY;
				end
			end
			MODE_START_CR: begin
				if (b == CH_LF) begin
					result.line_status = ST_EMPTY;
					state_nxt          = STATE_RESET;
				end else begin
					state_nxt.mode     = MODE_ERR_KEY;
					result.line_status = ST_BAD_KEY;
				end
			end
			MODE_VAL_LEAD, MODE_VAL: begin
				priority if (b == CH_LF) begin
					result.line_status = ST_OK;
					state_nxt          = STATE_RESET;
				end else if (b == CH_CR) begin
					state_nxt.mode = MODE_VAL_CR;
				end else if (b == CH_SPACE) begin
					// Defer interior spaces; leading ones are dropped
					if (cur.mode == MODE_VAL && cur.pending_spaces != SPACES_MAX) begin
						state_nxt.pending_spaces = cur.pending_spaces + 8'd1;
					end
				end else if (text_byte(b)) begin
					result.out_byte          = b;
					result.role              = ROLE_VAL;
					result.spaces_before     = cur.pending_spaces;
					state_nxt.pending_spaces = 8'd0;
					state_nxt.mode           = MODE_VAL;
				end else begin
					state_nxt.mode     = MODE_ERR_VAL;
					result.line_status = ST_BAD_VAL;
				end
			end
			MODE_VAL_CR: begin
				if (b == CH_LF) begin
					result.line_status = ST_OK;
					state_nxt          = STATE_RESET;
				end else begin
					state_nxt.mode     = MODE_ERR_VAL;
					result.line_status = ST_BAD_VAL;
				end
			end
			MODE_ERR_KEY: begin
				result.line_status = ST_BAD_KEY;
			end
			MODE_ERR_VAL: begin
				result.line_status = ST_BAD_VAL;
			end
		endcase
	end

endmodule

// ===== rtl/core/http_header_line_tokenizer.sv =====
// HTTP header line tokenizer: one result word for every accepted byte word.
// Each accepted word passes through the input register, then the result register.
// Throughput: one word per cycle unless out_ready stalls; the state loop is hhlt_step into state_q.
// Reset (arst_n low, asynchronous) empties both stages and returns the parser
// to line start with no deferred spaces and no error.
// Depends on hhlt_pkg and hhlt_step.
`timescale 1ns / 1ps

module http_header_line_tokenizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hhlt_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hhlt_pkg::out_word_t out_data
);
	import hhlt_pkg::*;

	in_word_t     in_s1;
	logic         valid_s1;
	out_word_t    res_s2;
	logic         valid_s2;
	parse_state_t state_q;

	out_word_t    step_res;
	parse_state_t step_nxt;
	logic         s2_free;
	logic         advance;

	assign s2_free  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	hhlt_step u_step (
		.in_word   (in_s1),
		.state     (state_q),
		.result    (step_res),
		.state_nxt (step_nxt)
	);

	// Hold the accepted input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// Advance the result register and the parse state together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (advance) begin
				state_q <= step_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_res;
		end
	end

`ifndef SYNTHESIS
	// An emitted byte never carries a line-ending or error status
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.role != ROLE_NONE |-> out_data.line_status == ST_BUSY)
		else $error("emitted byte with non-busy status");

	// Key bytes carry no deferred spaces
	a_key_no_spaces: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.role == ROLE_KEY |-> out_data.spaces_before == 8'd0)
		else $error("key byte with deferred spaces");

	// A halted key error repeats until a new block starts
	a_err_key_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q.mode == MODE_ERR_KEY && !in_s1.block_start
		|=> out_data.line_status == ST_BAD_KEY && out_data.role == ROLE_NONE)
		else $error("bad key error not sticky");

	// A halted value error repeats until a new block starts
	a_err_val_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q.mode == MODE_ERR_VAL && !in_s1.block_start
		|=> out_data.line_status == ST_BAD_VAL && out_data.role == ROLE_NONE)
		else $error("bad value error not sticky");
`endif

endmodule
